FILE: rtl/core/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg: power rail sequencer shared types and constants
// Request and result layouts, opcode and phase codes, sequence timings.
// ----------------------------------------------------------------------------
package prs_pkg;

	localparam int unsigned TIMER_BITS_DEF = 16;
	localparam int unsigned CFG_WIDTH      = 16;
	localparam int unsigned RETRY_LIMIT    = 3;

	localparam int unsigned OFF_DONE_WAIT_MS = 200;
	localparam int unsigned WAIT_3V3_MS      = 1000;
	localparam int unsigned PRESS_MS         = 1500;
	localparam int unsigned RELEASE_MS       = 500;
	localparam int unsigned PMIC_WAIT_MS     = 2000;

	localparam logic [15:0] RAIL_CYCLE_RST = 16'd1000;
	localparam logic [15:0] WARM_PULSE_RST = 16'd10;

	localparam logic [0:0] CFG_RAIL_CYCLE = 1'd0;
	localparam logic [0:0] CFG_WARM_PULSE = 1'd1;

	localparam logic [3:0] OP_TICK       = 4'd0;
	localparam logic [3:0] OP_INIT_ON    = 4'd1;
	localparam logic [3:0] OP_INIT_OFF   = 4'd2;
	localparam logic [3:0] OP_RESUME     = 4'd3;
	localparam logic [3:0] OP_POWER_ON   = 4'd4;
	localparam logic [3:0] OP_WAKEUP     = 4'd5;
	localparam logic [3:0] OP_HARD_OFF   = 4'd6;
	localparam logic [3:0] OP_HARD_RESET = 4'd7;
	localparam logic [3:0] OP_PMIC_RESET = 4'd8;
	localparam logic [3:0] OP_WARM_RESET = 4'd9;

	localparam logic [3:0] PH_INIT_OFF   = 4'd0;
	localparam logic [3:0] PH_OFF_DONE   = 4'd1;
	localparam logic [3:0] PH_WAIT3V3    = 4'd2;
	localparam logic [3:0] PH_PRESS      = 4'd3;
	localparam logic [3:0] PH_RELEASE    = 4'd4;
	localparam logic [3:0] PH_ON_DONE    = 4'd5;
	localparam logic [3:0] PH_RAIL_CYCLE = 4'd6;
	localparam logic [3:0] PH_PMIC_WAIT  = 4'd7;
	localparam logic [3:0] PH_WARM       = 4'd8;

	typedef struct packed {
		logic [3:0] opcode;
		logic       monitor_ready;
		logic       rail_3v3_ok;
		logic       rail_5v_ok;
		logic       key_long_press;
		logic       boost_enabled;
	} cmd_t;

	typedef struct packed {
		logic [3:0] seq_state;
		logic       rail_5v_enable;
		logic       pwron_drive;
		logic       reset_drive;
		logic       busy_res;
		logic       standby_request;
		logic       saved_5v_present;
		logic       boost_off_request;
		logic       backup_service;
	} res_t;

endpackage

FILE: rtl/core/power_rail_sequencer.sv
// ----------------------------------------------------------------------------
// power_rail_sequencer: processor power sequencer
// Data path: a request is held in the input register, and its result is registered in the output register.
// Throughput: one request per cycle; input stalls only while both registers are full and res_stall is high.
// Reset: phase init_off, flags, counters and lines clear, delays 1000/10 ms; only reset clears a halt.
// ----------------------------------------------------------------------------
module power_rail_sequencer #(
	parameter int unsigned TIMER_BITS = prs_pkg::TIMER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  prs_pkg::cmd_t                  cmd,
	output logic                           res_valid,
	input  logic                           res_stall,
	output prs_pkg::res_t                  res,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [prs_pkg::CFG_WIDTH-1:0]  cfg_data
);
	import prs_pkg::*;

	localparam int unsigned CW = (TIMER_BITS > CFG_WIDTH) ? TIMER_BITS : CFG_WIDTH;

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic                  res_valid_q;
	res_t                  res_q;
	logic [CFG_WIDTH-1:0]  rail_cycle_q;
	logic [CFG_WIDTH-1:0]  warm_pulse_q;

	logic [3:0]            phase_q;
	logic [TIMER_BITS-1:0] time_q;
	logic [2:0]            retry_q;
	logic                  wake_q;
	logic                  ready_q;
	logic                  halted_q;
	logic                  ln5_q;
	logic                  lnp_q;
	logic                  lnr_q;

	logic                  adv;
	logic                  accept;

	logic [3:0]            ph_n;
	logic [TIMER_BITS-1:0] tm_n;
	logic [TIMER_BITS-1:0] tm_inc;
	logic [CW-1:0]         tm_ext;
	logic [2:0]            rc_n;
	logic [3:0]            rc_next;
	logic                  wk_n;
	logic                  rdy_n;
	logic                  hlt_n;
	logic                  ln5_n;
	logic                  lnp_n;
	logic                  lnr_n;
	logic                  stby;
	logic                  saved;
	logic                  boff;
	logic                  svc;
	logic                  pwr_busy;

	assign adv       = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !adv;
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign tm_inc   = (time_q == {TIMER_BITS{1'b1}}) ? time_q : time_q + 1'b1;
	assign tm_ext   = CW'(tm_inc);
	assign rc_next  = {1'b0, retry_q} + 4'd1;
	assign pwr_busy = (phase_q == PH_ON_DONE) || (phase_q == PH_WAIT3V3) ||
		(phase_q == PH_PRESS) || (phase_q == PH_RELEASE);

	always_comb begin
		ph_n  = phase_q;
		tm_n  = time_q;
		rc_n  = retry_q;
		wk_n  = wake_q;
		rdy_n = ready_q;
		hlt_n = halted_q;
		ln5_n = ln5_q;
		lnp_n = lnp_q;
		lnr_n = lnr_q;
		stby  = 1'b0;
		saved = 1'b0;
		boff  = 1'b0;
		svc   = 1'b0;
		if (!halted_q) begin
			unique case (cmd_s1.opcode)
				OP_TICK: begin
					tm_n = tm_inc;
					if (cmd_s1.monitor_ready && ready_q) begin
						if (cmd_s1.key_long_press) begin
							ln5_n = 1'b0;
							boff  = 1'b1;
							stby  = 1'b1;
							saved = cmd_s1.rail_5v_ok;
							hlt_n = 1'b1;
						end else if (!cmd_s1.rail_5v_ok) begin
							stby  = 1'b1;
							hlt_n = 1'b1;
						end else begin
							unique case (phase_q)
								PH_ON_DONE: svc = 1'b1;
								PH_OFF_DONE: begin
									boff = cmd_s1.boost_enabled;
									if (tm_ext > CW'(OFF_DONE_WAIT_MS)) begin
										stby  = 1'b1;
										saved = 1'b1;
										hlt_n = 1'b1;
									end
								end
								PH_WAIT3V3, PH_PRESS: begin
									if (cmd_s1.rail_3v3_ok) begin
										if (phase_q == PH_PRESS)
											lnp_n = 1'b0;
										tm_n = '0;
										if (wake_q) begin
											wk_n  = 1'b0;
											lnr_n = 1'b1;
											ph_n  = PH_WARM;
										end else begin
											ph_n = PH_ON_DONE;
										end
									end else if (phase_q == PH_WAIT3V3) begin
										if (tm_ext > CW'(WAIT_3V3_MS)) begin
											lnp_n = 1'b1;
											rc_n  = '0;
											ph_n  = PH_PRESS;
											tm_n  = '0;
										end
									end else if (tm_ext > CW'(PRESS_MS)) begin
										rc_n  = rc_next[3] ? 3'd7 : rc_next[2:0];
										lnp_n = 1'b0;
										tm_n  = '0;
										if (rc_next <= 4'(RETRY_LIMIT)) begin
											ph_n = PH_RELEASE;
										end else begin
											ln5_n = 1'b0;
											ph_n  = PH_RAIL_CYCLE;
										end
									end
								end
								PH_RELEASE: begin
									if (tm_ext > CW'(RELEASE_MS)) begin
										lnp_n = 1'b1;
										ph_n  = PH_PRESS;
										tm_n  = '0;
									end
								end
								PH_RAIL_CYCLE: begin
									if (tm_ext > CW'(rail_cycle_q)) begin
										ln5_n = 1'b1;
										ph_n  = PH_WAIT3V3;
										tm_n  = '0;
									end
								end
								PH_WARM: begin
									if (tm_ext > CW'(warm_pulse_q)) begin
										lnr_n = 1'b0;
										lnp_n = 1'b0;
										ln5_n = 1'b1;
										ph_n  = PH_WAIT3V3;
										tm_n  = '0;
									end
								end
								PH_PMIC_WAIT: begin
									if (!cmd_s1.rail_3v3_ok || tm_ext > CW'(PMIC_WAIT_MS)) begin
										lnr_n = 1'b0;
										lnp_n = 1'b0;
										ph_n  = PH_WAIT3V3;
										tm_n  = '0;
									end
								end
								default: ;
							endcase
						end
					end
				end
				OP_INIT_ON, OP_POWER_ON: begin
					if (!pwr_busy) begin
						lnr_n = 1'b0;
						ln5_n = 1'b1;
						ph_n  = PH_WAIT3V3;
						tm_n  = '0;
					end
					if (cmd_s1.opcode == OP_INIT_ON) begin
						lnp_n = 1'b0;
						lnr_n = 1'b0;
						rdy_n = 1'b1;
					end
				end
				OP_INIT_OFF: begin
					ln5_n = 1'b0;
					lnp_n = 1'b0;
					lnr_n = 1'b0;
					ph_n  = PH_INIT_OFF;
					tm_n  = '0;
					rdy_n = 1'b1;
				end
				OP_RESUME: begin
					ln5_n = 1'b1;
					lnp_n = 1'b0;
					lnr_n = 1'b0;
					rdy_n = 1'b1;
					wk_n  = 1'b1;
					ph_n  = PH_WAIT3V3;
					tm_n  = '0;
				end
				OP_WAKEUP: begin
					wk_n  = 1'b1;
					lnr_n = 1'b0;
					ln5_n = 1'b1;
					ph_n  = PH_WAIT3V3;
					tm_n  = '0;
				end
				OP_HARD_OFF, OP_HARD_RESET: begin
					ln5_n = 1'b0;
					lnp_n = 1'b0;
					lnr_n = 1'b0;
					ph_n  = (cmd_s1.opcode == OP_HARD_OFF) ? PH_OFF_DONE : PH_RAIL_CYCLE;
					tm_n  = '0;
				end
				OP_PMIC_RESET, OP_WARM_RESET: begin
					lnr_n = 1'b1;
					ph_n  = (cmd_s1.opcode == OP_PMIC_RESET) ? PH_PMIC_WAIT : PH_WARM;
					tm_n  = '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			rail_cycle_q <= RAIL_CYCLE_RST;
			warm_pulse_q <= WARM_PULSE_RST;
			phase_q      <= PH_INIT_OFF;
			time_q       <= '0;
			retry_q      <= '0;
			wake_q       <= 1'b0;
			ready_q      <= 1'b0;
			halted_q     <= 1'b0;
			ln5_q        <= 1'b0;
			lnp_q        <= 1'b0;
			lnr_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RAIL_CYCLE: rail_cycle_q <= cfg_data;
					CFG_WARM_PULSE: warm_pulse_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			if (adv) begin
				phase_q  <= ph_n;
				time_q   <= tm_n;
				retry_q  <= rc_n;
				wake_q   <= wk_n;
				ready_q  <= rdy_n;
				halted_q <= hlt_n;
				ln5_q    <= ln5_n;
				lnp_q    <= lnp_n;
				lnr_q    <= lnr_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			cmd_s1 <= cmd;
		if (adv) begin
			res_q.seq_state         <= ph_n;
			res_q.rail_5v_enable    <= ln5_n;
			res_q.pwron_drive       <= lnp_n;
			res_q.reset_drive       <= lnr_n;
			res_q.busy_res          <= (ph_n != PH_OFF_DONE) && (ph_n != PH_ON_DONE);
			res_q.standby_request   <= stby;
			res_q.saved_5v_present  <= stby && saved;
			res_q.boost_off_request <= boff;
			res_q.backup_service    <= svc;
		end
	end

	a_stby_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && stby) |=> halted_q)
		else $error("standby request without halt");

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> (halted_q && $stable(phase_q) && $stable(ln5_q) &&
			$stable(lnp_q) && $stable(lnr_q)))
		else $error("sequence moved while halted");

	a_saved_only_stby: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.saved_5v_present) |-> res_q.standby_request)
		else $error("saved 5V flag without standby request");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && res_valid_q && res_stall))
		else $error("request stalled with room downstream");

	a_no_pulse_halted: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && halted_q) |-> !(stby || boff || svc))
		else $error("request pulse while halted");

endmodule

FILE: tb/sv/tb_power_rail_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_rail_sequencer: self-checking testbench for the power sequencer
// Drives command and tick requests through the valid/stall handshake with
// random gaps and receiver stalls, predicts every result from its own model
// of the sequence, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb_power_rail_sequencer;
	import prs_pkg::*;

	localparam logic [3:0] OP_UNDEF_LO = 4'd10;
	localparam logic [3:0] OP_UNDEF_HI = 4'd15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_t        cmd = '0;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// sequencer model state
	logic [3:0]  phase_q;
	logic [15:0] dwell_ms;
	logic [2:0]  retries;
	logic        warm_wake;
	logic        armed;
	logic        halted;
	logic        rail5;
	logic        pwron;
	logic        rst_line;
	logic [15:0] cycle_off_ms;
	logic [15:0] warm_ms;

	res_t        expected_results[$];
	int unsigned mismatch_count = 0;
	int unsigned requests_sent = 0;
	int unsigned sink_hold_cycles = 0;
	logic        src_idle_on = 1'b0;
	logic        sink_idle_on = 1'b0;

	power_rail_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void enter_phase(input logic [3:0] p);
		phase_q = p;
		dwell_ms = '0;
	endfunction

	function automatic void power_on_request();
		if (phase_q != PH_ON_DONE && phase_q != PH_WAIT3V3 &&
				phase_q != PH_PRESS && phase_q != PH_RELEASE) begin
			rst_line = 1'b0;
			rail5 = 1'b1;
			enter_phase(PH_WAIT3V3);
		end
	endfunction

	function automatic void rails_up();
		if (warm_wake) begin
			warm_wake = 1'b0;
			rst_line = 1'b1;
			enter_phase(PH_WARM);
		end else begin
			enter_phase(PH_ON_DONE);
		end
	endfunction

	function automatic res_t predict_sequencer(input cmd_t c);
		res_t r;
		logic stby;
		logic saved;
		logic boost_off;
		logic service;
		logic [3:0] attempt;
		stby = 1'b0;
		saved = 1'b0;
		boost_off = 1'b0;
		service = 1'b0;
		if (!halted) begin
			case (c.opcode)
			OP_TICK: begin
				if (dwell_ms != 16'hFFFF) dwell_ms = dwell_ms + 16'd1;
				if (c.monitor_ready && armed) begin
					if (c.key_long_press) begin
						rail5 = 1'b0;
						boost_off = 1'b1;
						stby = 1'b1;
						saved = c.rail_5v_ok;
						halted = 1'b1;
					end else if (!c.rail_5v_ok) begin
						stby = 1'b1;
						halted = 1'b1;
					end else begin
						case (phase_q)
						PH_ON_DONE: service = 1'b1;
						PH_OFF_DONE: begin
							if (c.boost_enabled) boost_off = 1'b1;
							if (dwell_ms > OFF_DONE_WAIT_MS) begin
								stby = 1'b1;
								saved = 1'b1;
								halted = 1'b1;
							end
						end
						PH_WAIT3V3: begin
							if (c.rail_3v3_ok) begin
								rails_up();
							end else if (dwell_ms > WAIT_3V3_MS) begin
								pwron = 1'b1;
								retries = '0;
								enter_phase(PH_PRESS);
							end
						end
						PH_PRESS: begin
							if (c.rail_3v3_ok) begin
								pwron = 1'b0;
								rails_up();
							end else if (dwell_ms > PRESS_MS) begin
								attempt = {1'b0, retries} + 4'd1;
								retries = (attempt > 4'd7) ? 3'd7 : attempt[2:0];
								pwron = 1'b0;
								if (attempt <= RETRY_LIMIT) begin
									enter_phase(PH_RELEASE);
								end else begin
									rail5 = 1'b0;
									enter_phase(PH_RAIL_CYCLE);
								end
							end
						end
						PH_RELEASE: begin
							if (dwell_ms > RELEASE_MS) begin
								pwron = 1'b1;
								enter_phase(PH_PRESS);
							end
						end
						PH_RAIL_CYCLE: begin
							if (dwell_ms > cycle_off_ms) begin
								rail5 = 1'b1;
								enter_phase(PH_WAIT3V3);
							end
						end
						PH_WARM: begin
							if (dwell_ms > warm_ms) begin
								rst_line = 1'b0;
								pwron = 1'b0;
								rail5 = 1'b1;
								enter_phase(PH_WAIT3V3);
							end
						end
						PH_PMIC_WAIT: begin
							if (!c.rail_3v3_ok || dwell_ms > PMIC_WAIT_MS) begin
								rst_line = 1'b0;
								pwron = 1'b0;
								enter_phase(PH_WAIT3V3);
							end
						end
						default: ;
						endcase
					end
				end
			end
			OP_INIT_ON: begin
				power_on_request();
				pwron = 1'b0;
				rst_line = 1'b0;
				armed = 1'b1;
			end
			OP_INIT_OFF: begin
				{rail5, pwron, rst_line} = '0;
				enter_phase(PH_INIT_OFF);
				armed = 1'b1;
			end
			OP_RESUME: begin
				rail5 = 1'b1;
				pwron = 1'b0;
				rst_line = 1'b0;
				armed = 1'b1;
				warm_wake = 1'b1;
				enter_phase(PH_WAIT3V3);
			end
			OP_POWER_ON: power_on_request();
			OP_WAKEUP: begin
				warm_wake = 1'b1;
				rst_line = 1'b0;
				rail5 = 1'b1;
				enter_phase(PH_WAIT3V3);
			end
			OP_HARD_OFF: begin
				{rail5, pwron, rst_line} = '0;
				enter_phase(PH_OFF_DONE);
			end
			OP_HARD_RESET: begin
				{rail5, pwron, rst_line} = '0;
				enter_phase(PH_RAIL_CYCLE);
			end
			OP_PMIC_RESET: begin
				rst_line = 1'b1;
				enter_phase(PH_PMIC_WAIT);
			end
			OP_WARM_RESET: begin
				rst_line = 1'b1;
				enter_phase(PH_WARM);
			end
			default: ;
			endcase
		end
		r.seq_state = phase_q;
		r.rail_5v_enable = rail5;
		r.pwron_drive = pwron;
		r.reset_drive = rst_line;
		r.busy_res = (phase_q != PH_OFF_DONE && phase_q != PH_ON_DONE);
		r.standby_request = stby;
		r.saved_5v_present = stby && saved;
		r.boost_off_request = boost_off;
		r.backup_service = service;
		return r;
	endfunction

	function automatic cmd_t make_request(input logic [3:0] op, input logic mon,
			input logic r33, input logic r5, input logic key, input logic boost);
		cmd_t c;
		c.opcode = op;
		c.monitor_ready = mon;
		c.rail_3v3_ok = r33;
		c.rail_5v_ok = r5;
		c.key_long_press = key;
		c.boost_enabled = boost;
		return c;
	endfunction

	function automatic cmd_t random_request(input logic [3:0] op);
		return make_request(op, $urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
	endfunction

	function automatic cmd_t random_tick(input logic r33);
		return make_request(OP_TICK, $urandom_range(0, 7) != 0, r33,
			$urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0, $urandom_range(0, 1));
	endfunction

	// steer clear of standby so the sequence keeps running
	function automatic cmd_t keep_running(input cmd_t c);
		cmd_t k;
		k = c;
		if (k.opcode == OP_TICK && armed && k.monitor_ready) begin
			if (k.key_long_press || !k.rail_5v_ok) begin
				k.monitor_ready = 1'b0;
			end else if (phase_q == PH_OFF_DONE && dwell_ms >= OFF_DONE_WAIT_MS) begin
				k.opcode = OP_POWER_ON;
			end
		end
		return k;
	endfunction

	task automatic send_request(input cmd_t c);
		if (src_idle_on && $urandom_range(0, 9) == 0) begin
			cmd_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		cmd = c;
		cmd_valid = 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		expected_results.push_back(predict_sequencer(c));
		if (c.opcode <= OP_WARM_RESET) requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_running(input cmd_t c);
		send_request(keep_running(c));
	endtask

	task automatic settle_block();
		cmd_valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [0:0] idx, input logic [15:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_RAIL_CYCLE) cycle_off_ms = value;
		else warm_ms = value;
	endtask

	task automatic test_directed_commands();
		settle_block();
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		write_register(CFG_RAIL_CYCLE, 16'd2);
		write_register(CFG_WARM_PULSE, 16'd1);
		// not yet armed: ticks only count time
		send_request(make_request(OP_TICK, 1, 1, 0, 1, 1));
		send_request(make_request(OP_UNDEF_HI, 1, 1, 1, 1, 1));
		send_request(make_request(OP_UNDEF_LO, 0, 0, 0, 0, 0));
		send_request(make_request(OP_INIT_OFF, 0, 0, 0, 0, 0));
		send_request(make_request(OP_TICK, 0, 0, 0, 1, 0));
		send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		send_request(make_request(OP_INIT_ON, 1, 1, 1, 1, 1));
		send_request(make_request(OP_INIT_ON, 0, 0, 0, 0, 0));
		send_request(make_request(OP_POWER_ON, 0, 0, 0, 0, 0));
		send_request(make_request(OP_TICK, 1, 1, 1, 0, 0));
		send_request(make_request(OP_TICK, 1, 0, 1, 0, 1));
		send_request(make_request(OP_POWER_ON, 1, 1, 1, 1, 1));
		send_request(make_request(OP_WARM_RESET, 0, 0, 0, 0, 0));
		send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		send_request(make_request(OP_PMIC_RESET, 0, 0, 0, 0, 0));
		send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		send_request(make_request(OP_WAKEUP, 0, 0, 0, 0, 0));
		send_request(make_request(OP_TICK, 1, 1, 1, 0, 0));
		send_request(make_request(OP_HARD_RESET, 0, 0, 0, 0, 0));
		repeat (3) send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		send_request(make_request(OP_RESUME, 0, 0, 0, 0, 0));
		send_request(make_request(OP_HARD_OFF, 0, 0, 0, 0, 0));
		send_request(make_request(OP_TICK, 1, 0, 1, 0, 1));
		send_request(make_request(OP_POWER_ON, 0, 0, 0, 0, 0));
	endtask

	task automatic test_delay_limits();
		settle_block();
		write_register(CFG_RAIL_CYCLE, 16'd0);
		write_register(CFG_WARM_PULSE, 16'd0);
		send_request(make_request(OP_WARM_RESET, 0, 0, 0, 0, 0));
		send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		send_request(make_request(OP_HARD_RESET, 0, 0, 0, 0, 0));
		send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		settle_block();
		write_register(CFG_RAIL_CYCLE, 16'hFFFF);
		write_register(CFG_WARM_PULSE, 16'hFFFF);
		send_request(make_request(OP_WARM_RESET, 0, 0, 0, 0, 0));
		repeat (5) send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		send_request(make_request(OP_HARD_RESET, 0, 0, 0, 0, 0));
		repeat (5) send_request(make_request(OP_TICK, 1, 1, 1, 0, 0));
		send_request(make_request(OP_POWER_ON, 0, 0, 0, 0, 0));
		settle_block();
		write_register(CFG_RAIL_CYCLE, RAIL_CYCLE_RST);
		write_register(CFG_WARM_PULSE, WARM_PULSE_RST);
	endtask

	task automatic test_backpressure();
		settle_block();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		sink_hold_cycles = 120;
		repeat (40) begin
			if ($urandom_range(0, 3) == 0)
				send_running(random_request($urandom_range(OP_TICK, OP_WARM_RESET)));
			else
				send_running(random_tick($urandom_range(0, 1)));
		end
		settle_block();
	endtask

	task automatic test_press_escalation();
		settle_block();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		send_request(make_request(OP_INIT_ON, 0, 0, 0, 0, 0));
		send_request(make_request(OP_HARD_OFF, 0, 0, 0, 0, 0));
		send_request(make_request(OP_WAKEUP, 0, 0, 0, 0, 0));
		// no 3.3V: the wait times out and the first power-on press starts
		while (phase_q != PH_PRESS)
			send_request(make_request(OP_TICK, 1, 0, 1, 0, $urandom_range(0, 1)));
		repeat (5) send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		send_request(make_request(OP_TICK, 1, 1, 1, 0, 0));
		while (phase_q == PH_WARM)
			send_request(make_request(OP_TICK, 1, 0, 1, 0, 0));
		send_request(make_request(OP_TICK, 1, 1, 1, 0, 0));
		send_request(make_request(OP_HARD_OFF, 0, 0, 0, 0, 0));
		send_request(make_request(OP_POWER_ON, 0, 0, 0, 0, 0));
	endtask

	task automatic run_random_items(input int unsigned target);
		int unsigned stop_at;
		int unsigned ticks;
		logic [3:0] op;
		stop_at = requests_sent + target;
		while (requests_sent < stop_at) begin
			ticks = $urandom_range(0, 30);
			case ($urandom_range(0, 9))
			0: op = $urandom_range(0, 1) ? OP_INIT_ON : OP_POWER_ON;
			1: op = $urandom_range(0, 1) ? OP_WAKEUP : OP_RESUME;
			2: op = OP_PMIC_RESET;
			3: op = OP_HARD_RESET;
			4: op = OP_HARD_OFF;
			5: op = OP_WARM_RESET;
			6: op = OP_INIT_OFF;
			default: begin
				op = $urandom_range(OP_TICK, OP_UNDEF_HI);
				ticks = $urandom_range(0, 3);
			end
			endcase
			send_running(random_request(op));
			repeat (ticks) send_running(random_tick($urandom_range(0, 2) != 0));
		end
	endtask

	task automatic test_random_traffic();
		for (int chunk = 0; chunk < 4; chunk++) begin
			settle_block();
			write_register(CFG_RAIL_CYCLE,
				(chunk == 2) ? 16'hFFFF : 16'($urandom_range(0, 40)));
			write_register(CFG_WARM_PULSE,
				(chunk == 1) ? 16'd0 : 16'($urandom_range(0, 40)));
			src_idle_on = (chunk < 3);
			sink_idle_on = (chunk < 3);
			run_random_items(100);
		end
	endtask

	task automatic test_standby_halt();
		int unsigned variant;
		variant = $urandom_range(0, 3);
		settle_block();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		send_request(make_request(OP_INIT_ON, 0, 0, 1, 0, 0));
		case (variant)
		0: send_request(make_request(OP_TICK, 1, 1, 1, 1, 1));
		1: send_request(make_request(OP_TICK, 1, 0, 0, 1, 0));
		2: send_request(make_request(OP_TICK, 1, 1, 0, 0, 1));
		default: begin
			send_request(make_request(OP_HARD_OFF, 0, 0, 0, 0, 0));
			while (!halted)
				send_request(make_request(OP_TICK, 1, 0, 1, 0, $urandom_range(0, 1)));
		end
		endcase
		// halted: everything after this is ignored
		repeat (30) send_request(random_request($urandom_range(OP_TICK, OP_UNDEF_HI)));
	endtask

	task automatic note_failure(input string msg);
		if (mismatch_count < 10) $display("%s", msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (want !== got)
			note_failure($sformatf("%s: expected %0h, got %0h", name, want, got));
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				note_failure($sformatf("result %h with no request pending", res));
			end else begin
				want = expected_results.pop_front();
				check_field("seq_state", want.seq_state, res.seq_state);
				check_field("rail_5v_enable", want.rail_5v_enable, res.rail_5v_enable);
				check_field("pwron_drive", want.pwron_drive, res.pwron_drive);
				check_field("reset_drive", want.reset_drive, res.reset_drive);
				check_field("busy_res", want.busy_res, res.busy_res);
				check_field("standby_request", want.standby_request, res.standby_request);
				check_field("saved_5v_present", want.saved_5v_present, res.saved_5v_present);
				check_field("boost_off_request", want.boost_off_request,
					res.boost_off_request);
				check_field("backup_service", want.backup_service, res.backup_service);
			end
		end
	end

	initial begin
		int unsigned hold_len;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_cycles != 0) begin
				hold_len = sink_hold_cycles;
				sink_hold_cycles = 0;
				res_stall = 1'b1;
				repeat (hold_len) @(negedge clk);
				res_stall = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				res_stall = 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				res_stall = 1'b0;
			end
		end
	end

	initial begin
		#(64'd10_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		phase_q = PH_INIT_OFF;
		dwell_ms = '0;
		retries = '0;
		warm_wake = 1'b0;
		armed = 1'b0;
		halted = 1'b0;
		{rail5, pwron, rst_line} = '0;
		cycle_off_ms = RAIL_CYCLE_RST;
		warm_ms = WARM_PULSE_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_commands();
		test_delay_limits();
		test_backpressure();
		test_press_escalation();
		test_random_traffic();
		test_standby_halt();
		settle_block();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
